[rtl/pac_pkg.sv]
// shared constants, widths and the segment record for the polygon area block
`default_nettype none
package pac_pkg;

	// coordinate and length formats
	localparam int COORD_BITS    = 24;
	localparam int LEN_FRAC_BITS = 4;

	// derived widths
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int SUM_W   = COORD_BITS + 1;
	localparam int HGT_W   = COORD_BITS + 3;
	localparam int TERM_W  = DIFF_W + HGT_W;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int RAD_W   = SQ_W + 2 * LEN_FRAC_BITS;
	localparam int LEN_W   = RAD_W / 2;
	localparam int REM_W   = LEN_W + 3;
	localparam int WGT_W   = LEN_W + SUM_W;
	localparam int AREA_W  = 63;
	localparam int ACC_W   = 64;
	localparam int LSUM_W  = 48;
	localparam int DSH_W   = LSUM_W + COORD_BITS;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);

	// one segment handed from the front to the back
	typedef struct packed {
		logic signed [TERM_W-1:0] term;
		logic [LEN_W-1:0]         len;
		logic signed [WGT_W-1:0]  wgt_east;
		logic signed [WGT_W-1:0]  wgt_north;
		logic                     has_seg;
		logic                     reversed;
		logic                     ends;
	} seg_rec_t;

endpackage
`default_nettype wire

[rtl/pac_fifo.sv]
// short register queue between the front and the back
`default_nettype none
module pac_fifo import pac_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire seg_rec_t push_rec,
	input  wire logic     pop,
	output seg_rec_t      pop_rec,
	output logic          full,
	output logic          empty
);

	seg_rec_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full    = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign pop_rec = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_ptr_q] <= push_rec;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop && !empty) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/pac_front.sv]
// front: takes vertex words, forms segments, multiplies and takes the root
`default_nettype none
module pac_front import pac_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic signed [COORD_BITS-1:0] baseline,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [COORD_BITS-1:0] vertex_east,
	input  wire logic signed [COORD_BITS-1:0] vertex_north,
	input  wire logic                         starts_line,
	input  wire logic                         line_reversed,
	input  wire logic                         ends_area,
	output logic                              push,
	output seg_rec_t                          push_rec,
	input  wire logic                         full
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_MUL  = 3'd1;
	localparam logic [2:0] F_SQI  = 3'd2;
	localparam logic [2:0] F_SQRT = 3'd3;
	localparam logic [2:0] F_WGT  = 3'd4;
	localparam logic [2:0] F_PUSH = 3'd5;
	localparam int         CNT_W  = $clog2(LEN_W);

	logic [2:0]                  state_q;
	logic                        have_prev_q;
	logic signed [COORD_BITS-1:0] prev_east_q;
	logic signed [COORD_BITS-1:0] prev_north_q;
	logic signed [DIFF_W-1:0]    de_q;
	logic signed [DIFF_W-1:0]    dn_q;
	logic signed [HGT_W-1:0]     hgt_q;
	logic signed [SUM_W-1:0]     es_q;
	logic signed [SUM_W-1:0]     ns_q;
	logic                        seg_q;
	logic                        rev_q;
	logic                        ends_q;
	logic signed [TERM_W-1:0]    term_q;
	logic signed [SQ_W-1:0]      de2_q;
	logic signed [SQ_W-1:0]      dn2_q;
	logic [RAD_W-1:0]            rad_q;
	logic [REM_W-1:0]            rem_q;
	logic [LEN_W-1:0]            root_q;
	logic [CNT_W-1:0]            cnt_q;
	logic signed [WGT_W-1:0]     we_q;
	logic signed [WGT_W-1:0]     wn_q;

	logic                        accept;
	logic signed [DIFF_W-1:0]    de_d;
	logic signed [DIFF_W-1:0]    dn_d;
	logic signed [HGT_W-1:0]     hgt_d;
	logic signed [SUM_W-1:0]     es_d;
	logic signed [SUM_W-1:0]     ns_d;
	logic [SQ_W-1:0]             sq_sum;
	logic [REM_W-1:0]            rem_sh;
	logic [REM_W-1:0]            trial;
	logic                        take;

	assign in_stall = (state_q != F_IDLE);
	assign accept   = in_valid && !in_stall;

	// differences, height sum and coordinate sums of the incoming segment
	assign de_d  = DIFF_W'(vertex_east) - DIFF_W'(prev_east_q);
	assign dn_d  = DIFF_W'(vertex_north) - DIFF_W'(prev_north_q);
	assign hgt_d = HGT_W'(vertex_north) + HGT_W'(prev_north_q) - (HGT_W'(baseline) <<< 1);
	assign es_d  = SUM_W'(vertex_east) + SUM_W'(prev_east_q);
	assign ns_d  = SUM_W'(vertex_north) + SUM_W'(prev_north_q);

	// one root digit per cycle
	assign sq_sum = $unsigned(de2_q + dn2_q);
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign take   = (rem_sh >= trial);

	assign push = (state_q == F_PUSH) && !full;
	always_comb begin
		push_rec.term      = term_q;
		push_rec.len       = root_q;
		push_rec.wgt_east  = we_q;
		push_rec.wgt_north = wn_q;
		push_rec.has_seg   = seg_q;
		push_rec.reversed  = rev_q;
		push_rec.ends      = ends_q;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				de_q  <= de_d;
				dn_q  <= dn_d;
				hgt_q <= hgt_d;
				es_q  <= es_d;
				ns_q  <= ns_d;
				rev_q <= line_reversed;
				ends_q <= ends_area;
			end
			F_MUL: begin
				term_q <= de_q * hgt_q;
				de2_q  <= de_q * de_q;
				dn2_q  <= dn_q * dn_q;
			end
			F_SQI: begin
				rad_q  <= RAD_W'(sq_sum) << (2 * LEN_FRAC_BITS);
				rem_q  <= '0;
				root_q <= '0;
			end
			F_SQRT: begin
				rad_q <= rad_q << 2;
				if (take) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[LEN_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[LEN_W-2:0], 1'b0};
				end
			end
			F_WGT: begin
				we_q <= $signed({1'b0, root_q}) * es_q;
				wn_q <= $signed({1'b0, root_q}) * ns_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			have_prev_q  <= 1'b0;
			prev_east_q  <= '0;
			prev_north_q <= '0;
			seg_q        <= 1'b0;
			cnt_q        <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						prev_east_q  <= vertex_east;
						prev_north_q <= vertex_north;
						have_prev_q  <= !ends_area;
						seg_q        <= !starts_line && have_prev_q;
						if (!starts_line && have_prev_q) state_q <= F_MUL;
						else if (ends_area)              state_q <= F_PUSH;
					end
				end
				F_MUL: state_q <= F_SQI;
				F_SQI: begin
					cnt_q   <= '0;
					state_q <= F_SQRT;
				end
				F_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(LEN_W - 1)) state_q <= F_WGT;
				end
				F_WGT:  state_q <= F_PUSH;
				F_PUSH: if (!full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/pac_back.sv]
// back: accumulates segments, divides out the centroid, holds the result word
`default_nettype none
module pac_back import pac_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  empty,
	input  wire seg_rec_t              pop_rec,
	output logic                       pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [AREA_W-1:0]   area_doubled,
	output logic signed [COORD_BITS-1:0] centroid_east,
	output logic signed [COORD_BITS-1:0] centroid_north,
	output logic                       centroid_valid
);

	localparam logic [1:0] B_RUN  = 2'd0;
	localparam logic [1:0] B_LOAD = 2'd1;
	localparam logic [1:0] B_DIV  = 2'd2;
	localparam logic [1:0] B_OUT  = 2'd3;
	localparam int         CNT_W  = $clog2(COORD_BITS);

	logic [1:0]                   state_q;
	logic                         sel_q;
	logic signed [AREA_W-1:0]     area_q;
	logic signed [ACC_W-1:0]      we_sum_q;
	logic signed [ACC_W-1:0]      wn_sum_q;
	logic [LSUM_W-1:0]            len_q;
	logic [ACC_W-1:0]             r_q;
	logic [DSH_W-1:0]             dsh_q;
	logic [COORD_BITS-1:0]        q_q;
	logic                         neg_q;
	logic                         ovf_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [COORD_BITS-1:0]        ce_q;
	logic [COORD_BITS-1:0]        cn_q;

	logic signed [AREA_W+1:0]     a_sum;
	logic signed [AREA_W-1:0]     a_nxt;
	logic signed [ACC_W:0]        we_s;
	logic signed [ACC_W:0]        wn_s;
	logic signed [ACC_W-1:0]      we_nxt;
	logic signed [ACC_W-1:0]      wn_nxt;
	logic [LSUM_W:0]              l_sum;
	logic [LSUM_W-1:0]            l_nxt;
	logic signed [ACC_W-1:0]      w_sel;
	logic [ACC_W-1:0]             mag;
	logic                         step_take;
	logic [COORD_BITS-1:0]        q_nxt;
	logic [COORD_BITS-1:0]        c_res;
	logic                         out_free;

	// saturate a 65-bit signed sum to 64 bits
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return s[ACC_W-1:0];
	endfunction

	// clamp the quotient magnitude and apply the sign
	function automatic logic [COORD_BITS-1:0] clamp_q(input logic neg, input logic big,
	                                                  input logic [COORD_BITS-1:0] q);
		logic [COORD_BITS-1:0] pmax;
		logic [COORD_BITS-1:0] nlim;
		pmax = {1'b0, {(COORD_BITS-1){1'b1}}};
		nlim = {1'b1, {(COORD_BITS-1){1'b0}}};
		if (neg) begin
			if (big || q > nlim) return nlim;
			return '0 - q;
		end
		if (big || q > pmax) return pmax;
		return q;
	endfunction

	assign out_free = !out_valid || !out_stall;
	assign pop      = (state_q == B_RUN) && !empty;

	// saturating accumulation of one segment
	always_comb begin
		a_sum = pop_rec.reversed ? (AREA_W+2)'(area_q) - (AREA_W+2)'(pop_rec.term)
		                         : (AREA_W+2)'(area_q) + (AREA_W+2)'(pop_rec.term);
		if (a_sum[AREA_W+1:AREA_W-1] == 3'b000 || a_sum[AREA_W+1:AREA_W-1] == 3'b111)
			a_nxt = a_sum[AREA_W-1:0];
		else if (a_sum[AREA_W+1])
			a_nxt = {1'b1, {(AREA_W-1){1'b0}}};
		else
			a_nxt = {1'b0, {(AREA_W-1){1'b1}}};
		we_s   = (ACC_W+1)'(we_sum_q) + (ACC_W+1)'(pop_rec.wgt_east);
		wn_s   = (ACC_W+1)'(wn_sum_q) + (ACC_W+1)'(pop_rec.wgt_north);
		we_nxt = sat_acc(we_s);
		wn_nxt = sat_acc(wn_s);
		l_sum  = (LSUM_W+1)'(len_q) + (LSUM_W+1)'(pop_rec.len);
		l_nxt  = l_sum[LSUM_W] ? {LSUM_W{1'b1}} : l_sum[LSUM_W-1:0];
	end

	// divider operand selection and one quotient bit per cycle
	assign w_sel     = sel_q ? wn_sum_q : we_sum_q;
	assign mag       = w_sel[ACC_W-1] ? ('0 - $unsigned(w_sel)) : $unsigned(w_sel);
	assign step_take = (DSH_W'(r_q) >= dsh_q);
	assign q_nxt     = {q_q[COORD_BITS-2:0], step_take};
	assign c_res     = clamp_q(neg_q, ovf_q, ovf_q ? q_q : q_nxt);

	// divider datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_LOAD: begin
				r_q   <= mag;
				dsh_q <= DSH_W'(len_q) << COORD_BITS;
				neg_q <= w_sel[ACC_W-1];
				ovf_q <= ((DSH_W+1)'(mag) >= ((DSH_W+1)'(len_q) << (COORD_BITS + 1)));
				q_q   <= '0;
			end
			B_DIV: begin
				if (step_take) r_q <= r_q - ACC_W'(dsh_q);
				dsh_q <= dsh_q >> 1;
				q_q   <= q_nxt;
			end
			default: begin
			end
		endcase
	end

	// sums, sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= B_RUN;
			sel_q          <= 1'b0;
			cnt_q          <= '0;
			area_q         <= '0;
			we_sum_q       <= '0;
			wn_sum_q       <= '0;
			len_q          <= '0;
			ce_q           <= '0;
			cn_q           <= '0;
			out_valid      <= 1'b0;
			area_doubled   <= '0;
			centroid_east  <= '0;
			centroid_north <= '0;
			centroid_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != B_OUT) out_valid <= 1'b0;
			case (state_q)
				B_RUN: begin
					if (!empty) begin
						if (pop_rec.has_seg) begin
							area_q   <= a_nxt;
							we_sum_q <= we_nxt;
							wn_sum_q <= wn_nxt;
							len_q    <= l_nxt;
						end
						if (pop_rec.ends) begin
							sel_q   <= 1'b0;
							state_q <= B_LOAD;
						end
					end
				end
				B_LOAD: begin
					cnt_q <= '0;
					if (len_q == '0) begin
						ce_q    <= '0;
						cn_q    <= '0;
						state_q <= B_OUT;
					end else begin
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (ovf_q || cnt_q == CNT_W'(COORD_BITS - 1)) begin
						if (sel_q) begin
							cn_q    <= c_res;
							state_q <= B_OUT;
						end else begin
							ce_q    <= c_res;
							sel_q   <= 1'b1;
							state_q <= B_LOAD;
						end
					end
				end
				B_OUT: begin
					if (out_free) begin
						out_valid      <= 1'b1;
						area_doubled   <= area_q;
						centroid_east  <= $signed(ce_q);
						centroid_north <= $signed(cn_q);
						centroid_valid <= (len_q != '0);
						area_q         <= '0;
						we_sum_q       <= '0;
						wn_sum_q       <= '0;
						len_q          <= '0;
						state_q        <= B_RUN;
					end
				end
				default: state_q <= B_RUN;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/polygon_area_and_centroid.sv]
// Polygon area and perimeter centroid accumulator.
// Input channel: one vertex word per handshake (in_valid / in_stall), with
// flags for the start of a boundary line, a reversed line and the last
// vertex of the area. Output channel: one result word per area
// (out_valid / out_stall): doubled signed area and the length-weighted
// centroid with its valid flag.
// The front takes a vertex that closes a segment through the multiply,
// the root setup, the digit-by-digit square root of the segment length
// (one digit a cycle, 29 digits), the weighting and the push; a vertex
// that opens a line goes to the push only if it also ends the area.
// Segments pass through a 4-word queue to the back, which adds each to its
// sums as it pops it. On the last vertex the back divides out both
// centroid coordinates with one shared divider, a load step and a
// bit-serial divide each. The user must write the baseline register
// through cfg_wr_en / cfg_wr_data only while the block is idle; the block
// does not enforce it. Reset clears the baseline, the line state, all sums
// and the queue. While out_stall is high the result word holds; the back
// waits with the next result, and the front stalls once the queue fills.
`default_nettype none
module polygon_area_and_centroid import pac_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic signed [COORD_BITS-1:0] cfg_wr_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [COORD_BITS-1:0] vertex_east,
	input  wire logic signed [COORD_BITS-1:0] vertex_north,
	input  wire logic                         starts_line,
	input  wire logic                         line_reversed,
	input  wire logic                         ends_area,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [AREA_W-1:0]          area_doubled,
	output logic signed [COORD_BITS-1:0]      centroid_east,
	output logic signed [COORD_BITS-1:0]      centroid_north,
	output logic                              centroid_valid
);

	logic signed [COORD_BITS-1:0] baseline_q;
	logic                         push;
	logic                         pop;
	logic                         full;
	logic                         empty;
	seg_rec_t                     push_rec;
	seg_rec_t                     pop_rec;

	// baseline register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) baseline_q <= '0;
		else if (cfg_wr_en) baseline_q <= cfg_wr_data;
	end

	pac_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.baseline      (baseline_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.vertex_east   (vertex_east),
		.vertex_north  (vertex_north),
		.starts_line   (starts_line),
		.line_reversed (line_reversed),
		.ends_area     (ends_area),
		.push          (push),
		.push_rec      (push_rec),
		.full          (full)
	);

	pac_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.full     (full),
		.empty    (empty)
	);

	pac_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (empty),
		.pop_rec        (pop_rec),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.area_doubled   (area_doubled),
		.centroid_east  (centroid_east),
		.centroid_north (centroid_north),
		.centroid_valid (centroid_valid)
	);

	// queue is never written when full nor read when empty
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("segment queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("segment queue underflow");

	// a result with zero length carries a zero centroid
	a_zero_centroid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !centroid_valid) |-> (centroid_east == '0 && centroid_north == '0))
		else $error("centroid not cleared for zero length");

endmodule
`default_nettype wire
